// ===== rtl/core/shuffled_combined_lcg_rng_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the shuffled combined LCG random source
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SHUFFLED_COMBINED_LCG_RNG_ASSERT_SVH
`define SHUFFLED_COMBINED_LCG_RNG_ASSERT_SVH

`ifndef SYNTH

// ante true in a cycle implies cons in the same cycle
`define SCL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("scl assertion failed");

// ante true in a cycle implies cons in the next cycle
`define SCL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("scl assertion failed");

`else

`define SCL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCL_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/scl_pkg.sv =====
// ---------------------------------------------------------------------------
// scl_pkg
// Constants and shared types of the shuffled combined LCG random source.
// ---------------------------------------------------------------------------
package scl_pkg;

  localparam int unsigned RECIP_SH = 47;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } scl_op_t;

  typedef struct packed {
    logic [15:0] mul;
    logic [15:0] quo;
    logic [13:0] rem;
    logic [30:0] modulus;
    logic [31:0] recip;
  } lcg_const_t;

  localparam logic [30:0] MOD1      = 31'd2147483563;
  localparam logic [30:0] MOD2      = 31'd2147483399;
  localparam logic [30:0] WRAP_SPAN = 31'd2147483562;
  localparam logic [30:0] CAP_LIMIT = 31'd2147483244;
  localparam logic [30:0] G1_RESET  = 31'd1;
  localparam logic [30:0] G2_RESET  = 31'd123456789;

  localparam logic [31:0] RECIP1 = 32'((64'd1 << RECIP_SH) / 64'd53668);
  localparam logic [31:0] RECIP2 = 32'((64'd1 << RECIP_SH) / 64'd52774);

  localparam lcg_const_t GEN1_C = '{mul: 16'd40014, quo: 16'd53668, rem: 14'd12211,
                                    modulus: MOD1, recip: RECIP1};
  localparam lcg_const_t GEN2_C = '{mul: 16'd40692, quo: 16'd52774, rem: 14'd3791,
                                    modulus: MOD2, recip: RECIP2};

  typedef struct packed {
    logic load_seed;
    logic warm_step;
    logic draw_commit;
  } scl_cmd_t;

  typedef struct packed {
    logic warm_last;
    logic out_free;
  } scl_status_t;

endpackage

// ===== rtl/core/scl_schrage.sv =====
// ---------------------------------------------------------------------------
// scl_schrage
// Three-stage multiplicative congruential step by Schrage's method.
// The result is registered in x1_r/p_r, then k_r/t_r, then r_r.
// ---------------------------------------------------------------------------
module scl_schrage (
  input  logic               clk,
  input  scl_pkg::lcg_const_t c,
  input  logic [30:0]        x,
  output logic [30:0]        r
);
  import scl_pkg::*;

  logic [30:0] x1_r;
  logic [62:0] p_r;
  logic [15:0] k_r;
  logic [15:0] t_r;
  logic [30:0] r_r;

  logic [15:0] k0;
  logic [31:0] kq;
  logic [31:0] t_full;
  logic [15:0] k_nxt;
  logic [15:0] t_nxt;
  logic [31:0] mt;
  logic [31:0] kr;
  logic [32:0] d;
  logic [30:0] r_nxt;

  // stage 2: quotient estimate and one correction
  always_comb begin
    k0     = p_r[62:RECIP_SH];
    kq     = 32'(k0) * 32'(c.quo);
    t_full = 32'(x1_r) - kq;
    if (t_full >= 32'(c.quo)) begin
      k_nxt = k0 + 16'd1;
      t_nxt = 16'(t_full - 32'(c.quo));
    end else begin
      k_nxt = k0;
      t_nxt = t_full[15:0];
    end
  end

  // stage 3: mul*t - k*rem, wrap if negative
  always_comb begin
    mt = 32'(c.mul) * 32'(t_r);
    kr = 32'(k_r) * 32'(c.rem);
    d  = 33'(mt) - 33'(kr);
    if (d[32]) begin
      r_nxt = 31'(d + 33'(c.modulus));
    end else begin
      r_nxt = d[30:0];
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x;
    p_r  <= 63'(x) * 63'(c.recip);
    k_r  <= k_nxt;
    t_r  <= t_nxt;
    r_r  <= r_nxt;
  end

  assign r = r_r;

endmodule

// ===== rtl/core/scl_datapath.sv =====
// ---------------------------------------------------------------------------
// scl_datapath
// Generator registers, shuffle table, slot select and result register.
// ---------------------------------------------------------------------------
`include "shuffled_combined_lcg_rng_assert.svh"

module scl_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scl_pkg::scl_cmd_t    cmd,
  output scl_pkg::scl_status_t status,
  input  logic [30:0]          in_seed_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [30:0]          out_random_value,
  output logic                 out_above_cap
);
  import scl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int WW    = $clog2(TABLE_DEPTH + 8);
  localparam int SLOT_SH = 56;
  localparam logic [31:0] SLOT_DIV   = 32'(64'd1 + 64'(WRAP_SPAN) / 64'(TABLE_DEPTH));
  localparam logic [31:0] SLOT_RECIP = 32'((64'd1 << SLOT_SH) / 64'(SLOT_DIV));

  logic [30:0]      g1_r;
  logic [30:0]      g2_r;
  logic [30:0]      lo_r;
  logic [WW-1:0]    w_r;
  logic [62:0]      sp_r;
  logic [IDX_W-1:0] slot_r;
  logic [30:0]      rd_r;
  logic             rv_r;
  logic [30:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic             out_valid_r;
  logic [30:0]      out_random_value_r;
  logic             out_above_cap_r;

  logic [30:0]      u1;
  logic [30:0]      u2;
  logic [30:0]      seed;
  logic [7:0]       s0;
  logic [7:0]       s1;
  logic [39:0]      sd_prod;
  logic [39:0]      sd_rem;
  logic [IDX_W-1:0] slot_nxt;
  logic [30:0]      tab;
  logic [31:0]      diff;
  logic [30:0]      y;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [30:0]      wr_data;

  scl_schrage u_gen1 (.clk(clk), .c(GEN1_C), .x(g1_r), .r(u1));
  scl_schrage u_gen2 (.clk(clk), .c(GEN2_C), .x(g2_r), .r(u2));

  assign seed = (in_seed_value == 31'd0) ? 31'd1 : in_seed_value;

  // slot = last output / SLOT_DIV, reciprocal estimate plus one correction
  always_comb begin
    s0      = {1'b0, sp_r[62:SLOT_SH]};
    sd_prod = 40'(s0) * 40'(SLOT_DIV);
    sd_rem  = 40'(lo_r) - sd_prod;
    s1      = (sd_rem >= 40'(SLOT_DIV)) ? s0 + 8'd1 : s0;
    if (s1 >= 8'(TABLE_DEPTH)) begin
      slot_nxt = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      slot_nxt = s1[IDX_W-1:0];
    end
  end

  always_comb begin
    tab  = rv_r ? rd_r : 31'd0;
    diff = 32'(tab) - 32'(u2);
    if ($signed(diff) < 32'sd1) begin
      diff = diff + 32'(WRAP_SPAN);
    end
    y = diff[30:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = u1;
    if (cmd.warm_step && (w_r < WW'(TABLE_DEPTH))) begin
      wr_en   = 1'b1;
      wr_addr = w_r[IDX_W-1:0];
    end else if (cmd.draw_commit) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sp_r   <= 63'(lo_r) * 63'(SLOT_RECIP);
    slot_r <= slot_nxt;
    rd_r   <= mem[slot_r];
    rv_r   <= vld_r[slot_r];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.load_seed) begin
      w_r <= WW'(TABLE_DEPTH + 7);
    end else if (cmd.warm_step) begin
      w_r <= w_r - WW'(1);
    end
    if (cmd.draw_commit) begin
      out_random_value_r <= y;
      out_above_cap_r    <= (y >= CAP_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r        <= G1_RESET;
      g2_r        <= G2_RESET;
      lo_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.load_seed) begin
        g1_r <= seed;
        g2_r <= seed;
      end else if (cmd.warm_step) begin
        g1_r <= u1;
        if (w_r == '0) begin
          lo_r <= u1;
        end
      end else if (cmd.draw_commit) begin
        g1_r <= u1;
        g2_r <= u2;
        lo_r <= y;
      end
      if (cmd.draw_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.warm_last  = (w_r == '0);
  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_random_value  = out_random_value_r;
  assign out_above_cap     = out_above_cap_r;

  `SCL_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.draw_commit, !out_valid_r || out_ready)
  `SCL_ASSERT_NXT(a_out_is_last, clk, rst_n, cmd.draw_commit, out_valid_r && (lo_r == out_random_value_r))
  `SCL_ASSERT_NXT(a_warm_end_lo, clk, rst_n, cmd.warm_step && (w_r == '0), lo_r == g1_r)

endmodule

// ===== rtl/core/scl_ctrl.sv =====
// ---------------------------------------------------------------------------
// scl_ctrl
// Sequencer for reseed warm-up and draw steps.
// ---------------------------------------------------------------------------
`include "shuffled_combined_lcg_rng_assert.svh"

module scl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  output scl_pkg::scl_cmd_t    cmd,
  input  scl_pkg::scl_status_t status
);
  import scl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_DRAW
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       draw_wait;

  assign draw_wait = (state_r == ST_DRAW) && (cnt_r == 2'd3);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cmd.load_seed   = 1'b0;
    cmd.warm_step   = 1'b0;
    cmd.draw_commit = 1'b0;
    in_ready        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = 2'd0;
        if (in_valid) begin
          cmd.load_seed = (in_cmd == CMD_RESEED);
          state_nxt     = (in_cmd == CMD_RESEED) ? ST_WARM : ST_DRAW;
        end
      end
      ST_WARM: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          cmd.warm_step = 1'b1;
          if (status.warm_last) begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (!draw_wait) begin
          cnt_nxt = cnt_r + 2'd1;
        end else if (status.out_free) begin
          cmd.draw_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SCL_ASSERT_IMP(a_cmd_excl, clk, rst_n, 1'b1, $onehot0(cmd))
  `SCL_ASSERT_NXT(a_warm_to_draw, clk, rst_n, cmd.warm_step && status.warm_last, state_r == ST_DRAW)
  `SCL_ASSERT_NXT(a_draw_stall, clk, rst_n, draw_wait && !status.out_free, draw_wait)

endmodule

// ===== rtl/core/shuffled_combined_lcg_rng.sv =====
// ---------------------------------------------------------------------------
// shuffled_combined_lcg_rng
// Combined two-generator LCG random source with a shuffle table.
//
//   channel  ports                               dir  beat
//   input    in_valid/in_ready, in_cmd,          in   draw, or reseed + draw
//            in_seed_value
//   result   out_valid/out_ready,                out  one per input beat
//            out_random_value, out_above_cap
//
// A draw follows the accept cycle through the 3-stage Schrage pipeline and
// the registered table read. A reseed first runs TABLE_DEPTH + 8 warm-up
// steps on the first generator.
// Reset clears the table valid bits at once; no clearing pass.
// A finished result sits in the output register while the next beat is taken;
// a draw that finishes before it is taken waits in its last cycle.
// ---------------------------------------------------------------------------
module shuffled_combined_lcg_rng #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [30:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_random_value,
  output logic        out_above_cap
);
  import scl_pkg::*;

  scl_cmd_t    cmd;
  scl_status_t status;

  scl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .cmd      (cmd),
    .status   (status)
  );

  scl_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .out_above_cap    (out_above_cap)
  );

endmodule
